// ===== rtl/ppu_pkg.sv =====
// Shared types and constants for the packed pattern unpacker.
// No dependencies; imported by every module of the block.
package ppu_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       pattern_start;
    logic       pattern_end;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [5:0] row_index;
    logic [3:0] channel;
    logic [2:0] field_index;
    logic [7:0] value;
    logic [5:0] channels_used;
    logic       incomplete;
    logic       last;
  } out_t;

  // results produced by one request, handed to the result buffer
  typedef struct packed {
    logic [1:0] n;
    out_t       r0;
    out_t       r1;
  } push_t;

  localparam logic KIND_SLOT    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [2:0] FLD_NOTE    = 3'd0;
  localparam logic [2:0] FLD_INSTR   = 3'd1;
  localparam logic [2:0] FLD_VOLUME  = 3'd2;
  localparam logic [2:0] FLD_EFFECT  = 3'd3;
  localparam logic [2:0] FLD_OPERAND = 3'd4;

  localparam logic REG_OBFUSCATED    = 1'b0;
  localparam logic REG_CHANNEL_LIMIT = 1'b1;

  localparam logic [7:0] KEY_START       = 8'd3;
  localparam logic [3:0] HIGH_CHAN_RESET = 4'd1;
  localparam logic [5:0] CHAN_LIMIT_RST  = 6'd16;

endpackage

// ===== rtl/ppu_core.sv =====
// Parser state and per-byte decode: turns one request into up to two results.
// Depends on ppu_pkg.
module ppu_core
  import ppu_pkg::*;
#(
  parameter int ROWS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       obfuscated,
  input  logic [5:0] channel_limit,
  input  in_t        item,
  input  logic       go,
  output push_t      push
);

  localparam int RW = $clog2(ROWS + 1);

  logic [7:0]    key_r, key_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [3:0]    chan_r, chan_nxt;
  logic [4:0]    pend_r, pend_nxt;
  logic [3:0]    high_r, high_nxt;

  logic [7:0]    key0;
  logic [RW-1:0] row0;
  logic [4:0]    pend0;
  logic [3:0]    high0;
  logic [7:0]    flag;
  logic [2:0]    fld;
  logic [4:0]    clr;
  logic          slot;
  logic [5:0]    lim;
  logic [5:0]    used;
  out_t          slot_res;
  out_t          sum_res;

  always_comb begin
    key0  = item.pattern_start ? KEY_START : key_r;
    row0  = item.pattern_start ? '0 : row_r;
    pend0 = item.pattern_start ? '0 : pend_r;
    high0 = item.pattern_start ? HIGH_CHAN_RESET : high_r;

    key_nxt  = key0;
    row_nxt  = row0;
    chan_nxt = chan_r;
    pend_nxt = pend0;
    high_nxt = high0;

    if (pend0[0]) begin
      fld = FLD_NOTE;
      clr = 5'b00001;
    end else if (pend0[1]) begin
      fld = FLD_INSTR;
      clr = 5'b00010;
    end else if (pend0[2]) begin
      fld = FLD_VOLUME;
      clr = 5'b00100;
    end else if (pend0[3]) begin
      fld = FLD_EFFECT;
      clr = 5'b01000;
    end else begin
      fld = FLD_OPERAND;
      clr = 5'b10000;
    end

    flag = item.data_byte ^ (obfuscated ? key0 : 8'd0);
    slot = (pend0 != '0);

    if (slot) begin
      pend_nxt = pend0 & ~clr;
      key_nxt  = key0 + 8'd1;
    end else if (row0 < RW'(ROWS)) begin
      key_nxt = key0 + 8'd1;
      if (flag == 8'd0) begin
        row_nxt = row0 + RW'(1);
      end else begin
        chan_nxt = flag[3:0];
        if (flag[3:0] > high0) high_nxt = flag[3:0];
        pend_nxt = {flag[4], flag[4], flag[5], flag[6], flag[7]};
      end
    end

    lim  = (channel_limit == 6'd0) ? 6'd1 : channel_limit;
    used = 6'(high_nxt) + 6'd1;
    if (used > lim) used = lim;

    slot_res             = '0;
    slot_res.kind        = KIND_SLOT;
    slot_res.row_index   = 6'(row0);
    slot_res.channel     = chan_r;
    slot_res.field_index = fld;
    slot_res.value       = item.data_byte;
    slot_res.last        = !item.pattern_end;

    sum_res               = '0;
    sum_res.kind          = KIND_SUMMARY;
    sum_res.channels_used = used;
    sum_res.incomplete    = (pend_nxt != '0);
    sum_res.last          = 1'b1;

    push.n  = {1'b0, slot} + {1'b0, item.pattern_end};
    push.r0 = slot ? slot_res : sum_res;
    push.r1 = sum_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r  <= KEY_START;
      row_r  <= '0;
      chan_r <= '0;
      pend_r <= '0;
      high_r <= HIGH_CHAN_RESET;
    end else if (go) begin
      key_r  <= key_nxt;
      row_r  <= row_nxt;
      chan_r <= chan_nxt;
      pend_r <= pend_nxt;
      high_r <= high_nxt;
    end
  end

endmodule

// ===== rtl/ppu_outbuf.sv =====
// Two-entry result buffer in front of the output channel.
// Depends on ppu_pkg.
module ppu_outbuf
  import ppu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_en,
  input  push_t      push,
  output logic [1:0] room,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data
);

  out_t       e0_r, e0_nxt;
  out_t       e1_r, e1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;
  logic [1:0] rem;
  out_t       head;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = e0_r;
  assign pop       = out_valid && out_ready;
  assign rem       = cnt_r - {1'b0, pop};
  assign room      = 2'd2 - rem;
  assign head      = pop ? e1_r : e0_r;

  always_comb begin
    e0_nxt  = e0_r;
    e1_nxt  = e1_r;
    cnt_nxt = rem + (push_en ? push.n : 2'd0);
    case (rem)
      2'd0: begin
        e0_nxt = push.r0;
        e1_nxt = push.r1;
      end
      2'd1: begin
        e0_nxt = head;
        e1_nxt = push.r0;
      end
      default: begin
        e0_nxt = e0_r;
        e1_nxt = e1_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

endmodule

// ===== rtl/packed_pattern_unpacker_top.sv =====
// Top level of the packed pattern unpacker: input register, config registers,
// parser core and result buffer. Depends on ppu_pkg, ppu_core, ppu_outbuf.
//
// Input channel (in_valid/in_ready/in_data) takes one pattern byte per request,
// tagged with pattern_start and pattern_end. Each request yields a slot write
// when data bytes are pending, a summary when pattern_end is set, both (slot
// first) or nothing (flag bytes and dropped bytes). The last flag marks the
// final result of a request.
// Output channel (out_valid/out_ready/out_data) carries those results in order.
// Path: an accepted request waits in the input register; the core parses it and
// writes its results into the result buffer, whose head drives out_data.
// Throughput: one request per cycle while the result buffer has room; a request
// with two results presents them in turn through the single output port.
// The input register and the two-entry result buffer keep the input taking
// requests while a finished result waits for out_ready; when the receiver
// stalls, in_ready drops once the buffer lacks room for the held request.
// Reset (rst_n low, synchronous) empties both stages, restores parser state
// and sets obfuscated to 0 and channel_limit to 16.
// cfg_we writes cfg_wdata into register cfg_idx (0 obfuscated, 1 limit).
module packed_pattern_unpacker_top
  import ppu_pkg::*;
#(
  parameter int ROWS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic       cfg_idx,
  input  logic [5:0] cfg_wdata
);

  logic       obf_r;
  logic [5:0] limit_r;
  logic       in_v_r;
  in_t        in_r;
  logic       go;
  logic [1:0] room;
  push_t      push;

  assign go       = in_v_r && (push.n <= room);
  assign in_ready = !in_v_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obf_r   <= 1'b0;
      limit_r <= CHAN_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_OBFUSCATED:    obf_r   <= cfg_wdata[0];
        REG_CHANNEL_LIMIT: limit_r <= cfg_wdata;
        default:           limit_r <= limit_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v_r <= 1'b1;
    end else if (go) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  ppu_core #(
    .ROWS(ROWS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .obfuscated   (obf_r),
    .channel_limit(limit_r),
    .item         (in_r),
    .go           (go),
    .push         (push)
  );

  ppu_outbuf u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_en  (go),
    .push     (push),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
